// ----- rtl/pgc_pkg.sv -----
`timescale 1ns / 1ps

package pgc_pkg;

    // Event classes
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_MOVE        = 3'd1;
    localparam logic [2:0] EV_PRESS       = 3'd2;
    localparam logic [2:0] EV_RELEASE     = 3'd3;
    localparam logic [2:0] EV_CLICK       = 3'd4;
    localparam logic [2:0] EV_DRAG_START  = 3'd5;
    localparam logic [2:0] EV_DRAG        = 3'd6;
    localparam logic [2:0] EV_DRAG_FINISH = 3'd7;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_WIDTH = 8;
    localparam int unsigned CFG_DATA_WIDTH  = 32;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLICK_HOLD   = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DCLICK_WIN   = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRAG_MIN     = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FINE_MIN     = 8'd3;

    // Register widths and reset values
    localparam int unsigned LIMIT_WIDTH = 24;
    localparam int unsigned DIST_WIDTH  = 15;
    localparam int unsigned DSQ_WIDTH   = 2 * DIST_WIDTH;

    localparam logic [LIMIT_WIDTH-1:0] CLICK_HOLD_RESET = 24'd200000;
    localparam logic [LIMIT_WIDTH-1:0] DCLICK_WIN_RESET = 24'd500000;
    // Thresholds are held squared: 328 squared and 4 squared
    localparam logic [DSQ_WIDTH-1:0]   DRAG_SQ_RESET    = 30'd107584;
    localparam logic [DSQ_WIDTH-1:0]   FINE_SQ_RESET    = 30'd16;

    localparam logic [7:0] CLICK_MAX = 8'd255;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] click_hold;
        logic [LIMIT_WIDTH-1:0] dclick_win;
        logic [DSQ_WIDTH-1:0]   drag_sq;
        logic [DSQ_WIDTH-1:0]   fine_sq;
    } cfg_t;

    typedef struct packed {
        logic over_drag;
        logic over_fine;
    } dist_flags_t;

endpackage

// ----- rtl/pointer_gesture_classifier_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_pos_x, s_pos_y, s_pressed, s_time_now_us
// m_        out        m_valid / m_ready      m_changed, m_event_type, m_click_count,
//                                             m_origin_x, m_origin_y
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample per cycle sustained while results are taken; a transferred sample enters the
// input register, then is classified into the result register.
// Gesture state is updated in the same cycle that fills the result register.
// Synchronous active-low reset clears the gesture state and loads default limits.
// A stalled result holds; one further sample waits in the input register.
// cfg_ready is always high; config writes take effect on the next cycle.

module pointer_gesture_classifier_core #(
    parameter int COORD_WIDTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_pos_x,
    input  logic signed [COORD_WIDTH-1:0]        s_pos_y,
    input  logic                                 s_pressed,
    input  logic [TIME_WIDTH-1:0]                s_time_now_us,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_changed,
    output logic [2:0]                           m_event_type,
    output logic [7:0]                           m_click_count,
    output logic signed [COORD_WIDTH-1:0]        m_origin_x,
    output logic signed [COORD_WIDTH-1:0]        m_origin_y,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pgc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [pgc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import pgc_pkg::*;

    localparam int HW = (TIME_WIDTH > LIMIT_WIDTH) ? TIME_WIDTH : LIMIT_WIDTH;

    cfg_t        cfg;
    dist_flags_t flags;

    // Input register
    logic                          in_valid_reg;
    logic signed [COORD_WIDTH-1:0] in_x_reg;
    logic signed [COORD_WIDTH-1:0] in_y_reg;
    logic                          in_pr_reg;
    logic [TIME_WIDTH-1:0]         in_now_reg;

    // Gesture state
    logic                          was_pressed_reg;
    logic signed [COORD_WIDTH-1:0] last_x_reg;
    logic signed [COORD_WIDTH-1:0] last_y_reg;
    logic signed [COORD_WIDTH-1:0] org_x_reg;
    logic signed [COORD_WIDTH-1:0] org_y_reg;
    logic [TIME_WIDTH-1:0]         press_time_reg;
    logic [2:0]                    last_ev_reg;
    logic [7:0]                    tally_reg;

    // Result register
    logic                          out_valid_reg;
    logic                          out_changed_reg;
    logic [2:0]                    out_ev_reg;
    logic [7:0]                    out_count_reg;
    logic signed [COORD_WIDTH-1:0] out_org_x_reg;
    logic signed [COORD_WIDTH-1:0] out_org_y_reg;

    logic                          advance;
    logic                          prev_drag;
    logic [TIME_WIDTH-1:0]         held;
    logic [HW-1:0]                 held_ext;
    logic [HW-1:0]                 hold_ext;
    logic [HW-1:0]                 win_ext;
    logic                          drag;
    logic                          moved;
    logic                          press_edge;
    logic                          release_edge;
    logic                          changed_next;
    logic [2:0]                    ev_next;
    logic [7:0]                    tally_next;
    logic signed [COORD_WIDTH-1:0] org_x_next;
    logic signed [COORD_WIDTH-1:0] org_y_next;

    pgc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pgc_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .pos_x (in_x_reg),
        .pos_y (in_y_reg),
        .org_x (org_x_reg),
        .org_y (org_y_reg),
        .cfg   (cfg),
        .flags (flags)
    );

    // Handshake: advance when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Time since the press began, modulo the time width
    assign held     = in_now_reg - press_time_reg;
    assign held_ext = HW'(held);
    assign hold_ext = HW'(cfg.click_hold);
    assign win_ext  = HW'(cfg.dclick_win);

    // Classify the sample
    always_comb begin
        prev_drag    = (last_ev_reg == EV_DRAG) || (last_ev_reg == EV_DRAG_START);
        drag         = in_pr_reg && was_pressed_reg &&
                       (prev_drag || flags.over_drag ||
                        ((held_ext > hold_ext) && flags.over_fine));
        moved        = (in_x_reg != last_x_reg) || (in_y_reg != last_y_reg);
        press_edge   = in_pr_reg && !was_pressed_reg;
        release_edge = !in_pr_reg && was_pressed_reg;
        changed_next = drag || moved || press_edge || release_edge;
        org_x_next   = org_x_reg;
        org_y_next   = org_y_reg;

        priority if (press_edge) begin
            ev_next    = EV_PRESS;
            org_x_next = in_x_reg;
            org_y_next = in_y_reg;
            if ((tally_reg == 8'd0) || (held_ext < win_ext)) begin
                tally_next = (tally_reg == CLICK_MAX) ? CLICK_MAX : tally_reg + 8'd1;
            end else begin
                tally_next = 8'd1;
            end
        end else if (release_edge) begin
            if (prev_drag) begin
                ev_next    = EV_DRAG_FINISH;
                tally_next = 8'd0;
            end else begin
                ev_next    = (held_ext < hold_ext) ? EV_CLICK : EV_RELEASE;
                tally_next = tally_reg;
            end
        end else if (drag) begin
            ev_next    = prev_drag ? EV_DRAG : EV_DRAG_START;
            tally_next = 8'd0;
        end else if (moved) begin
            ev_next    = EV_MOVE;
            tally_next = 8'd0;
        end else begin
            ev_next    = EV_NONE;
            tally_next = tally_reg;
        end
    end

    // Input register: hold while stalled, load on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_x_reg   <= s_pos_x;
            in_y_reg   <= s_pos_y;
            in_pr_reg  <= s_pressed;
            in_now_reg <= s_time_now_us;
        end
    end

    // Gesture state: advance with each classified sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_pressed_reg <= 1'b0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            org_x_reg       <= '0;
            org_y_reg       <= '0;
            press_time_reg  <= '0;
            last_ev_reg     <= EV_NONE;
            tally_reg       <= 8'd0;
        end else if (advance) begin
            was_pressed_reg <= in_pr_reg;
            last_x_reg      <= in_x_reg;
            last_y_reg      <= in_y_reg;
            org_x_reg       <= org_x_next;
            org_y_reg       <= org_y_next;
            if (press_edge) begin
                press_time_reg <= in_now_reg;
            end
            last_ev_reg     <= ev_next;
            tally_reg       <= tally_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_changed_reg <= changed_next;
            out_ev_reg      <= ev_next;
            out_count_reg   <= tally_next;
            out_org_x_reg   <= org_x_next;
            out_org_y_reg   <= org_y_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_changed     = out_changed_reg;
    assign m_event_type  = out_ev_reg;
    assign m_click_count = out_count_reg;
    assign m_origin_x    = out_org_x_reg;
    assign m_origin_y    = out_org_y_reg;

endmodule

// ----- rtl/pgc_cfg.sv -----
`timescale 1ns / 1ps

module pgc_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pgc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [pgc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output pgc_pkg::cfg_t                        cfg
);
    import pgc_pkg::*;

    cfg_t                  cfg_reg;
    logic [DIST_WIDTH-1:0] dist_val;
    logic [DSQ_WIDTH-1:0]  dist_sq;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Square the distance thresholds once, at write time
    assign dist_val = cfg_data[DIST_WIDTH-1:0];
    assign dist_sq  = dist_val * dist_val;

    // Take a register transfer; ignore indexes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.click_hold <= CLICK_HOLD_RESET;
            cfg_reg.dclick_win <= DCLICK_WIN_RESET;
            cfg_reg.drag_sq    <= DRAG_SQ_RESET;
            cfg_reg.fine_sq    <= FINE_SQ_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CLICK_HOLD: cfg_reg.click_hold <= cfg_data[LIMIT_WIDTH-1:0];
                REG_DCLICK_WIN: cfg_reg.dclick_win <= cfg_data[LIMIT_WIDTH-1:0];
                REG_DRAG_MIN:   cfg_reg.drag_sq    <= dist_sq;
                REG_FINE_MIN:   cfg_reg.fine_sq    <= dist_sq;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/pgc_dist.sv -----
`timescale 1ns / 1ps

module pgc_dist #(
    parameter int COORD_WIDTH = 16
) (
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] org_x,
    input  logic signed [COORD_WIDTH-1:0] org_y,
    input  pgc_pkg::cfg_t                 cfg,
    output pgc_pkg::dist_flags_t          flags
);
    import pgc_pkg::*;

    localparam int SUM_WIDTH = 2 * COORD_WIDTH + 1;
    localparam int CMP_WIDTH = (SUM_WIDTH > DSQ_WIDTH) ? SUM_WIDTH : DSQ_WIDTH;

    logic signed [COORD_WIDTH:0]   diff_x;
    logic signed [COORD_WIDTH:0]   diff_y;
    logic [COORD_WIDTH:0]          neg_x;
    logic [COORD_WIDTH:0]          neg_y;
    logic [COORD_WIDTH-1:0]        abs_x;
    logic [COORD_WIDTH-1:0]        abs_y;
    logic [2*COORD_WIDTH-1:0]      sq_x;
    logic [2*COORD_WIDTH-1:0]      sq_y;
    logic [SUM_WIDTH-1:0]          d2;
    logic [CMP_WIDTH-1:0]          d2_ext;
    logic [CMP_WIDTH-1:0]          drag_ext;
    logic [CMP_WIDTH-1:0]          fine_ext;

    // Absolute differences from the press origin
    assign diff_x = $signed({pos_x[COORD_WIDTH-1], pos_x})
                  - $signed({org_x[COORD_WIDTH-1], org_x});
    assign diff_y = $signed({pos_y[COORD_WIDTH-1], pos_y})
                  - $signed({org_y[COORD_WIDTH-1], org_y});
    assign neg_x  = -diff_x;
    assign neg_y  = -diff_y;
    assign abs_x  = diff_x[COORD_WIDTH] ? neg_x[COORD_WIDTH-1:0] : diff_x[COORD_WIDTH-1:0];
    assign abs_y  = diff_y[COORD_WIDTH] ? neg_y[COORD_WIDTH-1:0] : diff_y[COORD_WIDTH-1:0];

    // Squared distance, kept at full width so no saturation is needed
    assign sq_x = abs_x * abs_x;
    assign sq_y = abs_y * abs_y;
    assign d2   = {1'b0, sq_x} + {1'b0, sq_y};

    // Compare against the squared thresholds
    assign d2_ext   = CMP_WIDTH'(d2);
    assign drag_ext = CMP_WIDTH'(cfg.drag_sq);
    assign fine_ext = CMP_WIDTH'(cfg.fine_sq);

    assign flags.over_drag = d2_ext > drag_ext;
    assign flags.over_fine = d2_ext > fine_ext;

endmodule

// ----- verif/pointer_gesture_classifier_core_tb.sv -----
`timescale 1ns / 1ps

import pgc_pkg::*;

typedef struct {
    logic               changed;
    logic [2:0]         event_type;
    logic [7:0]         click_count;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
} gesture_t;

// Tracks the gesture state alongside the block and queues the expected results
class gesture_scoreboard;
    logic [LIMIT_WIDTH-1:0] hold_limit;
    logic [LIMIT_WIDTH-1:0] dclick_window;
    logic [DIST_WIDTH-1:0]  drag_min;
    logic [DIST_WIDTH-1:0]  fine_min;

    logic               was_down;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic signed [15:0] press_x;
    logic signed [15:0] press_y;
    logic [31:0]        press_t;
    logic [2:0]         last_event;
    logic [7:0]         tally;

    gesture_t pending[$];
    int       errors;
    int       checked;
    int       samples;
    int       event_seen[8];

    function new();
        hold_limit    = CLICK_HOLD_RESET;
        dclick_window = DCLICK_WIN_RESET;
        drag_min      = 15'd328;
        fine_min      = 15'd4;
        was_down      = 1'b0;
        last_x        = '0;
        last_y        = '0;
        press_x       = '0;
        press_y       = '0;
        press_t       = '0;
        last_event    = EV_NONE;
        tally         = '0;
        errors        = 0;
        checked       = 0;
        samples       = 0;
        foreach (event_seen[i]) event_seen[i] = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] index,
                            logic [CFG_DATA_WIDTH-1:0] data);
        case (index)
            REG_CLICK_HOLD: hold_limit    = data[LIMIT_WIDTH-1:0];
            REG_DCLICK_WIN: dclick_window = data[LIMIT_WIDTH-1:0];
            REG_DRAG_MIN:   drag_min      = data[DIST_WIDTH-1:0];
            REG_FINE_MIN:   fine_min      = data[DIST_WIDTH-1:0];
            default: ;
        endcase
    endfunction

    function longint unsigned sq_gap(logic signed [15:0] a, logic signed [15:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return d * d;
    endfunction

    // Classify one accepted sample and queue the result it must produce
    function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic pr, logic [31:0] now);
        logic [2:0]        prev_event;
        logic [7:0]        prev_tally;
        logic [31:0]       prev_press_t;
        logic [31:0]       held;
        logic [31:0]       gap;
        longint unsigned   d2;
        longint unsigned   drag_sq;
        longint unsigned   fine_sq;
        logic              prev_drag;
        logic              drag;
        logic              chg;
        logic [2:0]        ev;
        gesture_t          exp_res;

        prev_event   = last_event;
        prev_tally   = tally;
        prev_press_t = press_t;
        prev_drag    = (prev_event == EV_DRAG) || (prev_event == EV_DRAG_START);
        drag_sq      = longint'(drag_min) * longint'(drag_min);
        fine_sq      = longint'(fine_min) * longint'(fine_min);
        drag         = 1'b0;
        chg          = 1'b0;
        ev           = EV_NONE;

        // Decide whether a held press has become a drag
        if (pr && was_down) begin
            if (prev_drag) begin
                drag = 1'b1;
            end else begin
                d2   = sq_gap(x, press_x) + sq_gap(y, press_y);
                held = now - prev_press_t;
                if (held > hold_limit && d2 > fine_sq)
                    drag = 1'b1;
                else
                    drag = (d2 > drag_sq);
            end
        end

        // Movement and drags clear the click count
        if (drag || x != last_x || y != last_y) begin
            chg    = 1'b1;
            ev     = drag ? (prev_drag ? EV_DRAG : EV_DRAG_START) : EV_MOVE;
            last_x = x;
            last_y = y;
            tally  = '0;
        end

        // Press and release edges override the movement class
        if (was_down != pr) begin
            chg = 1'b1;
            if (pr) begin
                gap     = now - prev_press_t;
                ev      = EV_PRESS;
                press_x = x;
                press_y = y;
                press_t = now;
                if (prev_tally == 8'd0 || gap < dclick_window)
                    tally = (prev_tally == CLICK_MAX) ? CLICK_MAX : prev_tally + 8'd1;
                else
                    tally = 8'd1;
            end else begin
                held = now - press_t;
                if (prev_drag) begin
                    tally = '0;
                    ev    = EV_DRAG_FINISH;
                end else begin
                    tally = prev_tally;
                    ev    = (held < hold_limit) ? EV_CLICK : EV_RELEASE;
                end
            end
            was_down = pr;
        end
        last_event = ev;

        exp_res.changed     = chg;
        exp_res.event_type  = ev;
        exp_res.click_count = tally;
        exp_res.origin_x    = press_x;
        exp_res.origin_y    = press_y;
        pending.push_back(exp_res);
        samples++;
    endfunction

    // Compare one result transfer against the oldest expectation
    function void check_result(logic chg, logic [2:0] ev, logic [7:0] count,
                               logic signed [15:0] ox, logic signed [15:0] oy);
        gesture_t exp_res;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: changed %0d event %0d count %0d origin (%0d,%0d)",
                         chg, ev, count, ox, oy);
            return;
        end
        exp_res = pending.pop_front();
        checked++;
        event_seen[ev]++;
        if (chg !== exp_res.changed || ev !== exp_res.event_type ||
            count !== exp_res.click_count || ox !== exp_res.origin_x ||
            oy !== exp_res.origin_y) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch at result %0d: expected changed %0d event %0d ",
                          "count %0d origin (%0d,%0d), got changed %0d event %0d ",
                          "count %0d origin (%0d,%0d)"},
                         checked, exp_res.changed, exp_res.event_type,
                         exp_res.click_count, exp_res.origin_x, exp_res.origin_y,
                         chg, ev, count, ox, oy);
        end
    endfunction
endclass

module pointer_gesture_classifier_core_tb;

    localparam int HALF_PERIOD = 4;
    localparam int CYCLE_LIMIT = 500000;

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;

    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic signed [15:0]          s_pos_x       = '0;
    logic signed [15:0]          s_pos_y       = '0;
    logic                        s_pressed     = 1'b0;
    logic [31:0]                 s_time_now_us = '0;

    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic                        m_changed;
    logic [2:0]                  m_event_type;
    logic [7:0]                  m_click_count;
    logic signed [15:0]          m_origin_x;
    logic signed [15:0]          m_origin_y;

    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index     = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data      = '0;

    gesture_scoreboard sb = new();

    logic [31:0] now_us     = '0;
    int          gap_odds   = 0;
    int          stall_odds = 0;
    int          stall_left = 0;
    int          cycles     = 0;
    int          cfg_writes = 0;

    pointer_gesture_classifier_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pressed     (s_pressed),
        .s_time_now_us (s_time_now_us),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_changed     (m_changed),
        .m_event_type  (m_event_type),
        .m_click_count (m_click_count),
        .m_origin_x    (m_origin_x),
        .m_origin_y    (m_origin_y),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Check each result transfer, then pick the next stall burst
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_changed, m_event_type, m_click_count, m_origin_x, m_origin_y);
        if (stall_left == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            stall_left = $urandom_range(1, 17);
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Abandon a run that hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycles, sb.pending.size());
            $display("FAIL");
            $finish;
        end
    end

    // Present one sample, hold it until the transfer, then predict its result
    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                               logic pr, logic [31:0] t);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pos_x       <= x;
        s_pos_y       <= y;
        s_pressed     <= pr;
        s_time_now_us <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(x, y, pr, t);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] index,
                             logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(index, data);
        cfg_writes++;
    endtask

    // Reprogram all limits once the block has gone quiet
    task automatic load_limits(logic [31:0] hold, logic [31:0] win,
                               logic [31:0] drag, logic [31:0] fine);
        drain();
        write_reg(REG_CLICK_HOLD, hold);
        write_reg(REG_DCLICK_WIN, win);
        write_reg(REG_DRAG_MIN, drag);
        write_reg(REG_FINE_MIN, fine);
        // an unmapped index must leave every limit alone
        write_reg(8'($urandom_range(4, 255)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_coord();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 16383) - 8192);
    endfunction

    // Step a coordinate by about a threshold, landing often right on its edge
    function automatic logic signed [15:0] nudge(logic signed [15:0] c, int lim);
        int off;
        case ($urandom_range(0, 4))
            0: off = lim - 1;
            1: off = lim;
            2: off = lim + 1;
            3: off = $urandom_range(0, 3);
            default: off = $urandom_range(0, 2 * lim + 2);
        endcase
        if ($urandom_range(0, 1) == 1)
            off = -off;
        return 16'(c + off);
    endfunction

    // Time step around a limit, with the odd wild jump that wraps the counter
    function automatic logic [31:0] pick_gap(int unsigned lim);
        case ($urandom_range(0, 9))
            0: return lim - 1;
            1: return lim;
            2: return lim + 1;
            3: return $urandom;
            4, 5, 6: return $urandom_range(0, lim / 2);
            default: return $urandom_range(0, lim + lim / 4 + 2);
        endcase
    endfunction

    // Play one gesture with random content; noise breaks the sequences now and then
    task automatic play_gesture();
        logic signed [15:0] x;
        logic signed [15:0] y;
        int                 steps;
        x = pick_coord();
        y = pick_coord();
        now_us += pick_gap(sb.dclick_window);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                // one or more clicks at one spot
                steps = $urandom_range(1, 3);
                repeat (steps) begin
                    send_sample(x, y, 1'b1, now_us);
                    if ($urandom_range(0, 3) == 0) begin
                        now_us += pick_gap(sb.hold_limit) >> 1;
                        send_sample(x, y, 1'b1, now_us);
                    end
                    now_us += pick_gap(sb.hold_limit);
                    send_sample(x, y, 1'b0, now_us);
                    now_us += pick_gap(sb.dclick_window);
                end
            end
            3, 4: begin
                // press, wander about the drag distance, release
                send_sample(x, y, 1'b1, now_us);
                steps = $urandom_range(1, 5);
                repeat (steps) begin
                    now_us += $urandom_range(0, 20000);
                    if ($urandom_range(0, 3) != 0) begin
                        x = nudge(x, sb.drag_min);
                        if ($urandom_range(0, 1) == 1)
                            y = nudge(y, sb.drag_min);
                    end
                    send_sample(x, y, 1'b1, now_us);
                end
                now_us += pick_gap(sb.hold_limit);
                if ($urandom_range(0, 3) == 0)
                    x = nudge(x, sb.drag_min);
                send_sample(x, y, 1'b0, now_us);
            end
            5: begin
                // long hold with a small wobble
                send_sample(x, y, 1'b1, now_us);
                steps = $urandom_range(1, 3);
                repeat (steps) begin
                    now_us += pick_gap(sb.hold_limit);
                    x = nudge(x, sb.fine_min);
                    send_sample(x, y, 1'b1, now_us);
                end
                now_us += $urandom_range(0, 1000);
                send_sample(x, y, 1'b0, now_us);
            end
            6: begin
                // hover: moves and idle samples with the button up
                steps = $urandom_range(1, 5);
                repeat (steps) begin
                    if ($urandom_range(0, 2) == 0)
                        x = nudge(x, sb.drag_min);
                    now_us += $urandom_range(0, 50000);
                    send_sample(x, y, 1'b0, now_us);
                end
            end
            default: begin
                steps = $urandom_range(1, 4);
                repeat (steps) begin
                    if ($urandom_range(0, 3) == 0)
                        now_us = $urandom;
                    else
                        now_us += $urandom_range(0, 300000);
                    send_sample(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                                now_us);
                end
            end
        endcase
    endtask

    task automatic run_gestures(int n);
        int target;
        target = sb.samples + n;
        while (sb.samples < target) play_gesture();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples under the reset limits
        send_sample(16'sd0, 16'sd0, 1'b0, 32'd0);                 // nothing changes
        send_sample(16'sh7FFF, 16'sh8000, 1'b0, 32'd10);          // move to a corner
        send_sample(16'sh8000, 16'sh7FFF, 1'b0, 32'd20);          // and the opposite one
        send_sample(16'sh8000, 16'sh7FFF, 1'b1, 32'd1000);        // first press
        send_sample(16'sh8000, 16'sh7FFF, 1'b0, 32'd200999);      // click just inside the hold
        send_sample(16'sh8000, 16'sh7FFF, 1'b1, 32'd201100);      // second press in the window
        send_sample(16'sh8000, 16'sh7FFF, 1'b0, 32'd401100);      // held exactly the limit
        send_sample(16'sh8000, 16'sh7FFF, 1'b1, 32'd701100);      // one window later: restart
        send_sample(16'sh8148, 16'sh7FFF, 1'b1, 32'd701110);      // exactly the drag distance
        send_sample(16'sh8149, 16'sh7FFF, 1'b1, 32'd701120);      // one past it: drag start
        send_sample(16'sh8149, 16'sh7FFF, 1'b1, 32'd701130);      // held still: drag goes on
        send_sample(16'sh8149, 16'sh7FFF, 1'b0, 32'd701140);      // drag finish
        send_sample(16'sd0, 16'sd0, 1'b1, 32'hFFFF_FF00);         // press near the time wrap
        send_sample(16'sd5, 16'sd0, 1'b1, 32'h0003_0D41);         // long hold, tiny move
        send_sample(16'sd5, 16'sd0, 1'b0, 32'h0003_0D50);         // drag finish
        send_sample(16'sd5, 16'sd0, 1'b1, 32'hFFFF_FFF0);         // press just before the wrap
        send_sample(16'sd5, 16'sd0, 1'b0, 32'h0000_0010);         // click across the wrap
        send_sample(16'sd5, 16'sd0, 1'b0, 32'h0000_0020);         // idle sample
        send_sample(16'sd100, -16'sd100, 1'b1, 32'h0000_0040);    // move and press together
        send_sample(16'sd200, -16'sd200, 1'b0, 32'h0000_0080);    // move and release together
        send_sample(16'sd200, -16'sd200, 1'b1, 32'h0000_0100);    // press again
        send_sample(16'sd204, -16'sd200, 1'b1, 32'h0004_9400);    // exactly the fine distance
        send_sample(16'sd204, -16'sd200, 1'b0, 32'h0004_9500);

        // Random gestures under the reset limits
        now_us     = $urandom;
        gap_odds   = 4;
        stall_odds = 5;
        run_gestures(150);

        // All limits zero; the upper data bits must be dropped
        load_limits(32'hFF00_0000, 32'hFF00_0000, 32'hFFFF_8000, 32'hFFFF_8000);
        run_gestures(150);

        // All limits at their maximum, then a click train long enough to saturate
        load_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (260) begin
            now_us += $urandom_range(1, 1000);
            send_sample(16'sd64, -16'sd64, 1'b1, now_us);
            now_us += $urandom_range(1, 1000);
            send_sample(16'sd64, -16'sd64, 1'b0, now_us);
        end
        run_gestures(150);

        // Moderate limits: first a stretch with no idling, then heavy idling
        load_limits($urandom_range(1000, 400000), $urandom_range(1000, 800000),
                    $urandom_range(0, 2000), $urandom_range(0, 50));
        gap_odds   = 0;
        stall_odds = 0;
        run_gestures(150);
        gap_odds   = 2;
        stall_odds = 2;
        run_gestures(150);

        // Limits anywhere in their range
        load_limits($urandom, $urandom, $urandom, $urandom);
        gap_odds   = 4;
        stall_odds = 5;
        run_gestures(150);

        // Back to the reset limits (328 and 4 are the raw distances), no idling
        load_limits(32'(CLICK_HOLD_RESET), 32'(DCLICK_WIN_RESET), 32'd328, 32'd4);
        gap_odds   = 0;
        stall_odds = 0;
        run_gestures(150);

        drain();
        repeat (8) @(posedge aclk);

        $display("checked %0d results from %0d samples across %0d register writes",
                 sb.checked, sb.samples, cfg_writes);
        $display({"events seen: none %0d, move %0d, press %0d, release %0d, click %0d, ",
                  "drag start %0d, drag %0d, drag finish %0d"},
                 sb.event_seen[EV_NONE], sb.event_seen[EV_MOVE], sb.event_seen[EV_PRESS],
                 sb.event_seen[EV_RELEASE], sb.event_seen[EV_CLICK],
                 sb.event_seen[EV_DRAG_START], sb.event_seen[EV_DRAG],
                 sb.event_seen[EV_DRAG_FINISH]);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
